>>> hw/rtl/pps_pkg.sv
package pps_pkg;

   // Table geometry and field widths.
   localparam int SLOT_COUNT = 16;
   localparam int IDX_W      = $clog2(SLOT_COUNT);
   localparam int KIND_W     = 2;
   localparam int SLOT_W     = 4;
   localparam int TIME_W     = 16;
   localparam int PRI_W      = 8;
   localparam int CFG_W      = 5;

   // Request kinds; the remaining code changes nothing.
   typedef enum logic [KIND_W-1:0] {
      KIND_LOAD  = 2'd0,
      KIND_TICK  = 2'd1,
      KIND_CLEAR = 2'd2
   } kind_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_EXEC,
      ST_DONE
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic scan_step;
      logic execute;
      logic publish;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic scan_last;
      logic out_free;
   } status_type;

   // Increment that sticks at the all-ones value.
   function automatic logic [TIME_W-1:0] sat_inc(input logic [TIME_W-1:0] v);
      logic [TIME_W-1:0] r;
      r = (v == '1) ? v : v + TIME_W'(1);
      return r;
   endfunction

endpackage

>>> hw/rtl/pps_ctrl.sv
module pps_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   input  logic [pps_pkg::KIND_W-1:0] req_kind,
   output logic                      req_stall,
   input  pps_pkg::status_type       status,
   output pps_pkg::cmd_type          cmd
);
   import pps_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state: a tick scans the table, other kinds go straight to execution.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = (req_kind == KIND_TICK) ? ST_SCAN : ST_EXEC;
            end
         end
         ST_SCAN: begin
            if (status.scan_last) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs: requests are taken only while idle.
   always_comb begin
      req_stall = 1'b1;
      cmd       = '0;
      case (state_ff)
         ST_IDLE: begin
            req_stall   = 1'b0;
            cmd.capture = req_valid;
         end
         ST_SCAN: begin
            cmd.scan_step = 1'b1;
         end
         ST_EXEC: begin
            cmd.execute = 1'b1;
         end
         ST_DONE: begin
            cmd.publish = status.out_free;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

endmodule

>>> hw/rtl/pps_datapath.sv
module pps_datapath (
   input  logic                       clock,
   input  logic                       reset,
   input  pps_pkg::cmd_type           cmd,
   output pps_pkg::status_type        status,
   input  logic [pps_pkg::KIND_W-1:0] req_kind,
   input  logic [pps_pkg::SLOT_W-1:0] req_slot,
   input  logic [pps_pkg::TIME_W-1:0] req_arrival_time,
   input  logic [pps_pkg::TIME_W-1:0] req_burst_length,
   input  logic [pps_pkg::PRI_W-1:0]  req_priority_level,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ran_valid,
   output logic [pps_pkg::SLOT_W-1:0] rsp_ran_slot,
   output logic                       rsp_completed,
   output logic [pps_pkg::TIME_W-1:0] rsp_finish_time,
   output logic                       rsp_idle_tick,
   output logic [pps_pkg::TIME_W-1:0] rsp_idle_total,
   output logic                       rsp_all_done,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pps_pkg::CFG_W-1:0]  csr_active_slots
);
   import pps_pkg::*;

   // Configuration and captured request.
   logic [CFG_W-1:0]  active_ff;
   logic [KIND_W-1:0] kind_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic [TIME_W-1:0] arr_ff;
   logic [TIME_W-1:0] burst_ff;
   logic [PRI_W-1:0]  prio_ff;

   // Slot table; an entry's remaining time is meaningful only when its busy bit is set.
   logic [TIME_W-1:0]     arr_mem [SLOT_COUNT];
   logic [PRI_W-1:0]      pri_mem [SLOT_COUNT];
   logic [TIME_W-1:0]     rem_mem [SLOT_COUNT];
   logic [SLOT_COUNT-1:0] busy_ff;
   logic [TIME_W-1:0]     time_ff;
   logic [TIME_W-1:0]     idle_ff;

   // Scan position and best candidate so far.
   logic [IDX_W-1:0]  idx_ff;
   logic              found_ff;
   logic [IDX_W-1:0]  best_idx_ff;
   logic [PRI_W-1:0]  best_pri_ff;
   logic [TIME_W-1:0] best_arr_ff;
   logic [TIME_W-1:0] best_rem_ff;

   // Result fields staged by execution.
   logic              res_ran_ff;
   logic [SLOT_W-1:0] res_slot_ff;
   logic              res_completed_ff;
   logic [TIME_W-1:0] res_finish_ff;
   logic              res_idle_ff;

   // Output register.
   logic              rsp_valid_ff;
   logic              rsp_ran_valid_ff;
   logic [SLOT_W-1:0] rsp_ran_slot_ff;
   logic              rsp_completed_ff;
   logic [TIME_W-1:0] rsp_finish_time_ff;
   logic              rsp_idle_tick_ff;
   logic [TIME_W-1:0] rsp_idle_total_ff;
   logic              rsp_all_done_ff;

   logic [SLOT_COUNT-1:0] active_mask;
   logic                  work_left;
   logic [IDX_W-1:0]      rd_addr;
   logic [TIME_W-1:0]     rd_arr_ff;
   logic [PRI_W-1:0]      rd_pri_ff;
   logic [TIME_W-1:0]     rd_rem_ff;
   logic                  candidate;
   logic                  better;
   logic                  is_load;
   logic                  is_tick;
   logic                  is_clear;
   logic                  slot_ok;
   logic [IDX_W-1:0]      load_idx;
   logic [TIME_W-1:0]     new_rem;
   logic [TIME_W-1:0]     time_next;

   // Slots below the configured count take part; larger counts cover the whole table.
   always_comb begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
         active_mask[k] = (k < int'(active_ff));
      end
   end

   assign work_left = |(busy_ff & active_mask);

   // Kind decode of the captured request.
   assign is_load  = (kind_ff == KIND_LOAD);
   assign is_tick  = (kind_ff == KIND_TICK);
   assign is_clear = (kind_ff == KIND_CLEAR);
   assign slot_ok  = (int'(slot_ff) < SLOT_COUNT);
   assign load_idx = IDX_W'(slot_ff);

   // One table entry is examined per scan cycle. The registered read port is addressed
   // with the next scan position, so its data always belongs to the current one.
   assign rd_addr   = cmd.capture ? '0 : (cmd.scan_step ? idx_ff + IDX_W'(1) : idx_ff);
   assign candidate = active_mask[idx_ff] && busy_ff[idx_ff] && (rd_arr_ff <= time_ff);
   assign better    = candidate && (!found_ff || (rd_pri_ff < best_pri_ff)
                      || ((rd_pri_ff == best_pri_ff) && (rd_arr_ff < best_arr_ff)));

   assign new_rem   = best_rem_ff - TIME_W'(1);
   assign time_next = sat_inc(time_ff);

   // Status towards the controller.
   assign status.scan_last = (idx_ff == IDX_W'(SLOT_COUNT - 1));
   assign status.out_free  = !rsp_valid_ff || !rsp_stall;

   // Configuration register; writes must arrive only while the block is idle, which the block itself does not enforce.
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
      end else if (csr_valid) begin
         active_ff <= csr_active_slots;
      end
   end

   // Request capture.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         slot_ff  <= req_slot;
         arr_ff   <= req_arrival_time;
         burst_ff <= req_burst_length;
         prio_ff  <= req_priority_level;
      end
   end

   // Scan counter and running best.
   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.capture) begin
         idx_ff   <= '0;
         found_ff <= 1'b0;
      end else if (cmd.scan_step) begin
         idx_ff <= idx_ff + IDX_W'(1);
         if (better) begin
            found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan_step && better) begin
         best_idx_ff <= idx_ff;
         best_pri_ff <= rd_pri_ff;
         best_arr_ff <= rd_arr_ff;
         best_rem_ff <= rd_rem_ff;
      end
   end

   // Table memories: a load writes a slot, a tick that runs writes back the remaining time.
   always_ff @(posedge clock) begin
      if (cmd.execute && is_load && slot_ok) begin
         arr_mem[load_idx] <= arr_ff;
         pri_mem[load_idx] <= prio_ff;
      end
      rd_arr_ff <= arr_mem[rd_addr];
      rd_pri_ff <= pri_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         if (is_load && slot_ok) begin
            rem_mem[load_idx] <= burst_ff;
         end else if (is_tick && found_ff) begin
            rem_mem[best_idx_ff] <= new_rem;
         end
      end
      rd_rem_ff <= rem_mem[rd_addr];
   end

   // Busy bits stand for a non-zero remaining time.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= '0;
      end else if (cmd.execute) begin
         if (is_clear) begin
            busy_ff <= '0;
         end else if (is_load && slot_ok) begin
            busy_ff[load_idx] <= (burst_ff != '0);
         end else if (is_tick && found_ff) begin
            busy_ff[best_idx_ff] <= (new_rem != '0);
         end
      end
   end

   // Time and idle counters.
   always_ff @(posedge clock) begin
      if (reset) begin
         time_ff <= '0;
         idle_ff <= '0;
      end else if (cmd.execute) begin
         if (is_clear) begin
            time_ff <= '0;
            idle_ff <= '0;
         end else if (is_tick) begin
            time_ff <= time_next;
            if (!found_ff && work_left) begin
               idle_ff <= sat_inc(idle_ff);
            end
         end
      end
   end

   // Result staging for the transaction in hand.
   always_ff @(posedge clock) begin
      if (cmd.execute) begin
         res_ran_ff       <= is_tick && found_ff;
         res_slot_ff      <= (is_tick && found_ff) ? SLOT_W'(best_idx_ff) : '0;
         res_completed_ff <= is_tick && found_ff && (new_rem == '0);
         res_finish_ff    <= (is_tick && found_ff && (new_rem == '0)) ? time_next : '0;
         res_idle_ff      <= is_tick && !found_ff;
      end
   end

   // Output register; the table is already updated when it is loaded.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.publish) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.publish) begin
         rsp_ran_valid_ff   <= res_ran_ff;
         rsp_ran_slot_ff    <= res_slot_ff;
         rsp_completed_ff   <= res_completed_ff;
         rsp_finish_time_ff <= res_finish_ff;
         rsp_idle_tick_ff   <= res_idle_ff;
         rsp_idle_total_ff  <= idle_ff;
         rsp_all_done_ff    <= !work_left;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_ran_valid   = rsp_ran_valid_ff;
   assign rsp_ran_slot    = rsp_ran_slot_ff;
   assign rsp_completed   = rsp_completed_ff;
   assign rsp_finish_time = rsp_finish_time_ff;
   assign rsp_idle_tick   = rsp_idle_tick_ff;
   assign rsp_idle_total  = rsp_idle_total_ff;
   assign rsp_all_done    = rsp_all_done_ff;

endmodule

>>> hw/rtl/preemptive_priority_scheduler.sv
// Channel  Direction  Handshake            Payload
// req      in         req_valid/req_stall  kind, slot, arrival_time, burst_length,
//                                          priority_level
// rsp      out        rsp_valid/rsp_stall  ran_valid, ran_slot, completed, finish_time,
//                                          idle_tick, idle_total, all_done
// csr      in         csr_valid/csr_ready  active_slots
//
// A tick scans the table one slot per cycle through a single read port, then updates it,
// then registers the result. Load, clear and unused kinds skip the scan and go straight
// to execution. One transaction is in hand at a time, but the next request is accepted
// while a result waits in the output register.
// Synchronous reset empties every slot and zeroes time, idle count and active_slots.
// A stalled result holds; a waiting finished result delays only the next publication.
module preemptive_priority_scheduler (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [pps_pkg::KIND_W-1:0] req_kind,
   input  logic [pps_pkg::SLOT_W-1:0] req_slot,
   input  logic [pps_pkg::TIME_W-1:0] req_arrival_time,
   input  logic [pps_pkg::TIME_W-1:0] req_burst_length,
   input  logic [pps_pkg::PRI_W-1:0]  req_priority_level,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output logic                       rsp_ran_valid,
   output logic [pps_pkg::SLOT_W-1:0] rsp_ran_slot,
   output logic                       rsp_completed,
   output logic [pps_pkg::TIME_W-1:0] rsp_finish_time,
   output logic                       rsp_idle_tick,
   output logic [pps_pkg::TIME_W-1:0] rsp_idle_total,
   output logic                       rsp_all_done,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [pps_pkg::CFG_W-1:0]  csr_active_slots
);
   import pps_pkg::*;

   cmd_type    cmd;
   status_type status;

   // Sequencing of each transaction.
   pps_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Slot table, counters, scan and output register.
   pps_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_kind           (req_kind),
      .req_slot           (req_slot),
      .req_arrival_time   (req_arrival_time),
      .req_burst_length   (req_burst_length),
      .req_priority_level (req_priority_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ran_valid      (rsp_ran_valid),
      .rsp_ran_slot       (rsp_ran_slot),
      .rsp_completed      (rsp_completed),
      .rsp_finish_time    (rsp_finish_time),
      .rsp_idle_tick      (rsp_idle_tick),
      .rsp_idle_total     (rsp_idle_total),
      .rsp_all_done       (rsp_all_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_active_slots   (csr_active_slots)
   );

   // A tick either runs a slot or is idle, and only a running slot can complete.
   a_outcome_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_idle_tick && rsp_ran_valid) && (!rsp_completed || rsp_ran_valid))
      else $error("result reports both a run and an idle tick, or completion without a run");

   // A slot that ran without finishing still has work, so the table cannot be done.
   a_unfinished_not_done: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ran_valid && !rsp_completed |-> !rsp_all_done)
      else $error("all_done reported while the running slot still has work");

   // Completion happens after time has advanced at least once.
   a_finish_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_completed |-> rsp_finish_time != '0)
      else $error("completion reported with a zero finish time");

endmodule

>>> tb/tb_preemptive_priority_scheduler.sv
`timescale 1ns / 1ps

module tb_preemptive_priority_scheduler;
   import pps_pkg::*;

   // The spare kind code has no name in the package.
   localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
   localparam int CYCLE_LIMIT     = 1000000;
   localparam int SETTLE_CYCLES   = SLOT_COUNT + 8;
   localparam int HOLD_CYCLES     = 400;
   localparam int PHASE_COUNT     = 9;
   localparam int ITEMS_PER_PHASE = 205;

   typedef struct packed {
      logic [KIND_W-1:0] kind;
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] arrival;
      logic [TIME_W-1:0] burst;
      logic [PRI_W-1:0]  prio;
   } sched_req_type;

   typedef struct packed {
      logic              ran_valid;
      logic [SLOT_W-1:0] ran_slot;
      logic              completed;
      logic [TIME_W-1:0] finish_time;
      logic              idle_tick;
      logic [TIME_W-1:0] idle_total;
      logic              all_done;
   } outcome_type;

   // Tracks the task table and time as the block should see them, and holds the
   // outcomes still owed by the block in order of acceptance.
   class schedule_tracker_type;
      logic [TIME_W-1:0] arrival_of [SLOT_COUNT];
      logic [PRI_W-1:0]  prio_of [SLOT_COUNT];
      logic [TIME_W-1:0] work_of [SLOT_COUNT];
      logic [TIME_W-1:0] now_tick;
      logic [TIME_W-1:0] idle_count;
      logic [CFG_W-1:0]  active_slots;
      outcome_type       outcome_q[$];
      int unsigned       errors;

      function new();
         for (int k = 0; k < SLOT_COUNT; k++) begin
            arrival_of[k] = '0;
            prio_of[k]    = '0;
            work_of[k]    = '0;
         end
         now_tick     = '0;
         idle_count   = '0;
         active_slots = '0;
         errors       = 0;
      endfunction

      function int live_count();
         return (active_slots > SLOT_COUNT) ? SLOT_COUNT : int'(active_slots);
      endfunction

      function bit work_pending();
         for (int k = 0; k < live_count(); k++)
            if (work_of[k] != 0) return 1'b1;
         return 1'b0;
      endfunction

      function logic [TIME_W-1:0] step_up(logic [TIME_W-1:0] v);
         return (v == '1) ? v : v + 1'b1;
      endfunction

      function void set_active(logic [CFG_W-1:0] v);
         active_slots = v;
      endfunction

      // Applies one transaction to the tracked state and returns the outcome it gives.
      function outcome_type schedule_outcome(sched_req_type r);
         outcome_type o;
         int          best;
         bit          found;
         o     = '0;
         best  = 0;
         found = 1'b0;
         case (r.kind)
            KIND_LOAD: begin
               arrival_of[r.slot] = r.arrival;
               prio_of[r.slot]    = r.prio;
               work_of[r.slot]    = r.burst;
            end
            KIND_CLEAR: begin
               for (int k = 0; k < SLOT_COUNT; k++) work_of[k] = '0;
               now_tick   = '0;
               idle_count = '0;
            end
            KIND_TICK: begin
               // Lowest priority number wins, then earlier arrival, then lower index.
               for (int k = 0; k < live_count(); k++) begin
                  if (work_of[k] == 0 || arrival_of[k] > now_tick) continue;
                  if (!found || prio_of[k] < prio_of[best] ||
                      (prio_of[k] == prio_of[best] && arrival_of[k] < arrival_of[best])) begin
                     best  = k;
                     found = 1'b1;
                  end
               end
               if (found) begin
                  o.ran_valid   = 1'b1;
                  o.ran_slot    = best[SLOT_W-1:0];
                  work_of[best] = work_of[best] - 1'b1;
                  now_tick      = step_up(now_tick);
                  if (work_of[best] == 0) begin
                     o.completed   = 1'b1;
                     o.finish_time = now_tick;
                  end
               end else begin
                  o.idle_tick = 1'b1;
                  if (work_pending()) idle_count = step_up(idle_count);
                  now_tick = step_up(now_tick);
               end
            end
            default: begin
            end
         endcase
         o.idle_total = idle_count;
         o.all_done   = !work_pending();
         return o;
      endfunction

      function void note_request(sched_req_type r);
         outcome_q.push_back(schedule_outcome(r));
      endfunction

      function void compare_field(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
            errors++;
         end
      endfunction

      function void check_outcome(outcome_type got);
         outcome_type want;
         if (outcome_q.size() == 0) begin
            $display("%0t: outcome arrived with none expected, actual %p", $time, got);
            errors++;
            return;
         end
         want = outcome_q.pop_front();
         compare_field("ran_valid", 32'(want.ran_valid), 32'(got.ran_valid));
         compare_field("ran_slot", 32'(want.ran_slot), 32'(got.ran_slot));
         compare_field("completed", 32'(want.completed), 32'(got.completed));
         compare_field("finish_time", 32'(want.finish_time), 32'(got.finish_time));
         compare_field("idle_tick", 32'(want.idle_tick), 32'(got.idle_tick));
         compare_field("idle_total", 32'(want.idle_total), 32'(got.idle_total));
         compare_field("all_done", 32'(want.all_done), 32'(got.all_done));
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [KIND_W-1:0] req_kind = '0;
   logic [SLOT_W-1:0] req_slot = '0;
   logic [TIME_W-1:0] req_arrival_time = '0;
   logic [TIME_W-1:0] req_burst_length = '0;
   logic [PRI_W-1:0]  req_priority_level = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic              rsp_ran_valid;
   logic [SLOT_W-1:0] rsp_ran_slot;
   logic              rsp_completed;
   logic [TIME_W-1:0] rsp_finish_time;
   logic              rsp_idle_tick;
   logic [TIME_W-1:0] rsp_idle_total;
   logic              rsp_all_done;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_active_slots = '0;

   logic              hold_request = 1'b0;
   logic              hold_done = 1'b0;
   int                hold_count = 0;
   int                stall_mode = 0;
   int                stall_left = 0;
   int                cycle_count = 0;
   int                phase_slots [PHASE_COUNT] = '{16, 31, 0, 5, 17, 1, 16, 12, 2};

   schedule_tracker_type board = new();

   preemptive_priority_scheduler dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_kind           (req_kind),
      .req_slot           (req_slot),
      .req_arrival_time   (req_arrival_time),
      .req_burst_length   (req_burst_length),
      .req_priority_level (req_priority_level),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_ran_valid      (rsp_ran_valid),
      .rsp_ran_slot       (rsp_ran_slot),
      .rsp_completed      (rsp_completed),
      .rsp_finish_time    (rsp_finish_time),
      .rsp_idle_tick      (rsp_idle_tick),
      .rsp_idle_total     (rsp_idle_total),
      .rsp_all_done       (rsp_all_done),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_active_slots   (csr_active_slots)
   );

   // A 10 ns clock.
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // The receiver changes its stall pattern every so often, apart from one long hold-off.
   always @(posedge clock) begin
      if (hold_request && !hold_done) begin
         rsp_stall <= 1'b1;
         if (hold_count == HOLD_CYCLES) hold_done <= 1'b1;
         hold_count <= hold_count + 1;
      end else begin
         if (stall_left == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_left <= $urandom_range(10, 150);
         end else begin
            stall_left <= stall_left - 1;
         end
         case (stall_mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= ($urandom_range(0, 99) < 70);
            default: rsp_stall <= ~rsp_stall;
         endcase
      end
   end

   // Every accepted result is checked against the oldest expected outcome.
   always @(posedge clock) begin
      outcome_type got;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         got.ran_valid   = rsp_ran_valid;
         got.ran_slot    = rsp_ran_slot;
         got.completed   = rsp_completed;
         got.finish_time = rsp_finish_time;
         got.idle_tick   = rsp_idle_tick;
         got.idle_total  = rsp_idle_total;
         got.all_done    = rsp_all_done;
         board.check_outcome(got);
      end
   end

   // Watchdog on the whole run.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("preemptive_priority_scheduler verification failed");
      $finish;
   end

   // Offers one transaction and returns once it has been accepted; valid stays high.
   task automatic send_request(input sched_req_type r);
      req_valid          <= 1'b1;
      req_kind           <= r.kind;
      req_slot           <= r.slot;
      req_arrival_time   <= r.arrival;
      req_burst_length   <= r.burst;
      req_priority_level <= r.prio;
      do @(posedge clock); while (req_stall !== 1'b0);
      board.note_request(r);
   endtask

   task automatic send_fields(input logic [KIND_W-1:0] kind, input logic [SLOT_W-1:0] slot,
                              input logic [TIME_W-1:0] arrival,
                              input logic [TIME_W-1:0] burst, input logic [PRI_W-1:0] prio);
      sched_req_type r;
      r.kind    = kind;
      r.slot    = slot;
      r.arrival = arrival;
      r.burst   = burst;
      r.prio    = prio;
      send_request(r);
   endtask

   // Waits until every outcome is in, then lets the block finish any work in hand.
   task automatic settle();
      req_valid <= 1'b0;
      while (board.outcome_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active(input logic [CFG_W-1:0] v);
      csr_valid        <= 1'b1;
      csr_active_slots <= v;
      do @(posedge clock); while (csr_ready !== 1'b1);
      board.set_active(v);
      csr_valid <= 1'b0;
   endtask

   // Mostly ticks and loads near the current time with small bursts and close
   // priorities, so that preemption and ties happen often; now and then a full-range
   // load, a clear or the spare kind.
   function automatic sched_req_type random_request();
      sched_req_type r;
      int            live;
      int unsigned   roll;
      live      = board.live_count();
      roll      = $urandom_range(0, 99);
      r.slot    = SLOT_W'($urandom_range(0, 15));
      r.arrival = TIME_W'($urandom_range(0, 65535));
      r.burst   = TIME_W'($urandom_range(0, 65535));
      r.prio    = PRI_W'($urandom_range(0, 255));
      if (roll < 55) begin
         r.kind = KIND_TICK;
      end else if (roll < 89) begin
         r.kind = KIND_LOAD;
         if (live > 0 && $urandom_range(0, 99) < 80)
            r.slot = SLOT_W'($urandom_range(0, live - 1));
         roll = $urandom_range(0, 99);
         if (roll < 70) r.arrival = TIME_W'(board.now_tick + $urandom_range(0, 12));
         else if (roll < 85) r.arrival = TIME_W'($urandom_range(0, board.now_tick));
         roll = $urandom_range(0, 99);
         if (roll < 10) r.burst = '0;
         else if (roll < 85) r.burst = TIME_W'($urandom_range(1, 8));
         else if (roll < 95) r.burst = TIME_W'($urandom_range(9, 40));
         roll = $urandom_range(0, 99);
         if (roll < 50) r.prio = PRI_W'($urandom_range(0, 3));
         else if (roll < 60) r.prio = ($urandom_range(0, 1) == 0) ? 8'h00 : 8'hFF;
      end else if (roll < 94) begin
         r.kind = KIND_CLEAR;
      end else begin
         r.kind = KIND_SPARE;
      end
      return r;
   endfunction

   // Sends random transactions in bursts with gaps; optionally stages the long hold-off
   // halfway through while the sender keeps offering transactions back to back.
   task automatic run_random(input int count, input bit with_hold);
      int left;
      int burst_len;
      left = count;
      while (left > 0) begin
         burst_len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(1, 8);
         while (burst_len > 0 && left > 0) begin
            send_request(random_request());
            burst_len--;
            left--;
            if (with_hold && left == count / 2) begin
               hold_request <= 1'b1;
               while (!hold_done) send_request(random_request());
            end
         end
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset no slot is active: a loaded slot takes no part yet.
      send_fields(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0);
      send_fields(KIND_LOAD, 4'd0, 16'd0, 16'd3, 8'd5);
      send_fields(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0);
      settle();
      write_active(5'd16);

      // Spare kind, index tie, a later arrival preempting, and a task that never arrives.
      send_fields(KIND_SPARE, 4'hF, 16'hFFFF, 16'hFFFF, 8'hFF);
      send_fields(KIND_LOAD, 4'd1, 16'd0, 16'd2, 8'd5);
      send_fields(KIND_LOAD, 4'd2, 16'd3, 16'd1, 8'd0);
      send_fields(KIND_LOAD, 4'd15, 16'hFFFF, 16'hFFFF, 8'hFF);
      repeat (6) send_fields(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0);

      // An empty load, then a tie on priority decided by arrival time.
      send_fields(KIND_LOAD, 4'd3, 16'd0, 16'd0, 8'd0);
      send_fields(KIND_LOAD, 4'd4, 16'd2, 16'd1, 8'hFF);
      send_fields(KIND_LOAD, 4'd5, 16'd1, 16'd1, 8'hFF);
      repeat (4) send_fields(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0);
      send_fields(KIND_CLEAR, 4'd0, 16'd0, 16'd0, 8'd0);
      send_fields(KIND_TICK, 4'd0, 16'd0, 16'd0, 8'd0);

      // Random phases, each under its own number of active slots.
      for (int p = 0; p < PHASE_COUNT; p++) begin
         settle();
         write_active(phase_slots[p][CFG_W-1:0]);
         run_random(ITEMS_PER_PHASE, p == 0);
      end
      settle();

      board.errors += board.outcome_q.size();
      if (board.errors == 0)
         $display("preemptive_priority_scheduler verification clean");
      else
         $display("preemptive_priority_scheduler verification failed");
      $finish;
   end

endmodule
